### hdl/mpmc_pkg.sv
// ----------------------------------------------------------------------------
// mpmc_pkg
// Shared types, constants and helpers for the multi-pattern match counter.
// ----------------------------------------------------------------------------
package mpmc_pkg;

  localparam int NODES           = 16384;
  localparam int NODE_W          = 14;
  localparam int NCOUNT_W        = 15;   // holds NODES itself
  localparam int ALPHABET        = 26;
  localparam int LETTER_W        = 5;
  localparam int PATTERNS        = 1024;
  localparam int ID_W            = 11;
  localparam int CADDR_W         = 10;
  localparam int MAX_PATTERN_LEN = 64;
  localparam int DEPTH_W         = 7;
  localparam int COUNT_W         = 32;
  localparam int HERE_W          = 7;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  // op codes
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_BUILD = 3'd1;
  localparam logic [2:0] OP_SCAN  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_LETTER = 2'd2;
  localparam logic [1:0] ST_PHASE  = 2'd3;

  // node row layout: children, fail link, pattern id, queue slot
  localparam int CHILDREN_W = ALPHABET * NODE_W;
  localparam int FAIL_LSB   = CHILDREN_W;
  localparam int PAT_LSB    = FAIL_LSB + NODE_W;
  localparam int Q_LSB      = PAT_LSB + ID_W;
  localparam int ROW_W      = Q_LSB + NODE_W;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [ROW_W-1:0]    row_t;

  function automatic node_t child_of(input row_t row, input letter_t k);
    return row[int'(k)*NODE_W +: NODE_W];
  endfunction

  function automatic node_t fail_of(input row_t row);
    return row[FAIL_LSB +: NODE_W];
  endfunction

endpackage

### hdl/mpmc_if.sv
// ----------------------------------------------------------------------------
// mpmc interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mpmc_req_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           op;
  logic [7:0]           symbol;
  logic                 last;
  logic [mpmc_pkg::ID_W-1:0] pattern_index;

  modport source (output valid, op, symbol, last, pattern_index, input ready);
  modport sink   (input valid, op, symbol, last, pattern_index, output ready);
endinterface

interface mpmc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mpmc_pkg::ID_W-1:0]    pattern_id;
  logic [mpmc_pkg::COUNT_W-1:0] match_count;
  logic [mpmc_pkg::HERE_W-1:0]  matches_here;
  logic [1:0]                   status;

  modport source (output valid, pattern_id, match_count, matches_here, status,
                  input ready);
  modport sink   (input valid, pattern_id, match_count, matches_here, status,
                  output ready);
endinterface

### hdl/multi_pattern_match_counter.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_counter
// Aho-Corasick matcher over A-Z built around a node memory and a count memory.
// ----------------------------------------------------------------------------
// Load letter: L_CHK (+L_INIT if new). Read: R_WAIT. Bad ops: none.
//   Scan byte: C_PCHK per failure step, C_TCHK per chain node, C_CINC per hit.
// Build: B_QRD..B_UROW per node, B_K per letter slot, B_PCHK per failure step.
// One item at a time; the node memory's single read port sets the pace.
// Reset (and op 4): control state cleared, then S_ROOT zeroes the root row's
// children and pattern id, other rows' on allocation, counts on id assignment.
module multi_pattern_match_counter (
  input  logic clk,
  input  logic rst,
  mpmc_req_if.sink   req,
  mpmc_rsp_if.source rsp
);
  import mpmc_pkg::*;

  localparam logic [3:0] S_ROOT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] L_CHK    = 4'd2;
  localparam logic [3:0] L_INIT   = 4'd3;
  localparam logic [3:0] B_START  = 4'd4;
  localparam logic [3:0] B_QRD    = 4'd5;
  localparam logic [3:0] B_QWAIT  = 4'd6;
  localparam logic [3:0] B_UROW   = 4'd7;
  localparam logic [3:0] B_K      = 4'd8;
  localparam logic [3:0] B_PCHK   = 4'd9;
  localparam logic [3:0] B_WF     = 4'd10;
  localparam logic [3:0] B_WQ     = 4'd11;
  localparam logic [3:0] C_PCHK   = 4'd12;
  localparam logic [3:0] C_TCHK   = 4'd13;
  localparam logic [3:0] C_CINC   = 4'd14;
  localparam logic [3:0] R_WAIT   = 4'd15;

  // memories: trie rows and per-pattern counts
  row_t   node_mem [NODES];
  count_t cnt_mem  [PATTERNS];
  row_t   node_rd;
  count_t cnt_rd;

  // memory strobes
  logic    nr_en;
  node_t   nr_addr;
  logic    nw_kids, nw_one, nw_fail, nw_pat, nw_q;
  node_t   nw_addr, nw_node;
  letter_t nw_k;
  id_t     nw_id;
  logic    cr_en, cw_en;
  logic [CADDR_W-1:0] cr_addr, cw_addr;
  count_t  cw_data;

  always_ff @(posedge clk) begin
    if (nw_kids) node_mem[nw_addr][0 +: CHILDREN_W] <= '0;
    if (nw_one)  node_mem[nw_addr][int'(nw_k)*NODE_W +: NODE_W] <= nw_node;
    if (nw_fail) node_mem[nw_addr][FAIL_LSB +: NODE_W] <= nw_node;
    if (nw_pat)  node_mem[nw_addr][PAT_LSB +: ID_W] <= nw_id;
    if (nw_q)    node_mem[nw_addr][Q_LSB +: NODE_W] <= nw_node;
    if (nr_en)   node_rd <= node_mem[nr_addr];
  end

  always_ff @(posedge clk) begin
    if (cw_en) cnt_mem[cw_addr] <= cw_data;
    if (cr_en) cnt_rd <= cnt_mem[cr_addr];
  end

  // control registers
  logic [3:0]          state, state_next;
  node_t               scan_node, scan_node_next;
  node_t               load_node, load_node_next;
  logic [NCOUNT_W-1:0] nodes_used, nodes_used_next;
  id_t                 next_id, next_id_next;
  logic                links_built, links_built_next;
  logic [DEPTH_W-1:0]  load_depth, load_depth_next;
  logic [NCOUNT_W-1:0] head, head_next, tail, tail_next;
  logic                out_valid, out_valid_next;

  // working registers
  letter_t             k_r, k_r_next;
  logic                last_r, last_r_next;
  letter_t             kk, kk_next;
  node_t               u_r, u_r_next, c_r, c_r_next, f_r, f_r_next;
  node_t               p_r, p_r_next, tf_r, tf_r_next;
  row_t                u_row, u_row_next;
  logic [HERE_W-1:0]   here, here_next;
  id_t                 o_pid, o_pid_next;
  count_t              o_cnt, o_cnt_next;
  logic [HERE_W-1:0]   o_here, o_here_next;
  logic [1:0]          o_status, o_status_next;

  logic    accept;
  logic    letter_ok;
  letter_t letter;
  node_t   pc, cc;
  id_t     tid;
  logic    id_ok;

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign accept    = req.valid && req.ready;
  assign letter_ok = (req.symbol >= CHAR_A) && (req.symbol <= CHAR_Z);
  assign letter    = LETTER_W'(req.symbol - CHAR_A);

  assign rsp.valid        = out_valid;
  assign rsp.pattern_id   = o_pid;
  assign rsp.match_count  = o_cnt;
  assign rsp.matches_here = o_here;
  assign rsp.status       = o_status;

  always_comb begin
    state_next       = state;
    scan_node_next   = scan_node;
    load_node_next   = load_node;
    nodes_used_next  = nodes_used;
    next_id_next     = next_id;
    links_built_next = links_built;
    load_depth_next  = load_depth;
    head_next        = head;
    tail_next        = tail;
    out_valid_next   = out_valid && !rsp.ready;
    k_r_next         = k_r;
    last_r_next      = last_r;
    kk_next          = kk;
    u_r_next         = u_r;
    c_r_next         = c_r;
    f_r_next         = f_r;
    p_r_next         = p_r;
    tf_r_next        = tf_r;
    u_row_next       = u_row;
    here_next        = here;
    o_pid_next       = o_pid;
    o_cnt_next       = o_cnt;
    o_here_next      = o_here;
    o_status_next    = o_status;

    nr_en = 1'b0;  nr_addr = '0;
    nw_kids = 1'b0; nw_one = 1'b0; nw_fail = 1'b0; nw_pat = 1'b0; nw_q = 1'b0;
    nw_addr = '0; nw_node = '0; nw_k = '0; nw_id = '0;
    cr_en = 1'b0; cr_addr = '0; cw_en = 1'b0; cw_addr = '0; cw_data = '0;

    pc    = child_of(node_rd, k_r);
    cc    = child_of(u_row, kk);
    tid   = node_rd[PAT_LSB +: ID_W];
    id_ok = (tid != '0) && (tid <= ID_W'(PATTERNS));

    unique case (state)
      S_ROOT: begin
        // root row: no children, no pattern
        nw_kids = 1'b1; nw_pat = 1'b1; nw_addr = '0;
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          k_r_next       = letter;
          last_r_next    = req.last;
          out_valid_next = 1'b1;   // default: answer now
          o_pid_next     = '0;
          o_cnt_next     = '0;
          o_here_next    = '0;
          o_status_next  = ST_OK;
          case (req.op)
            OP_LOAD: begin
              if (links_built) begin
                o_status_next = ST_PHASE;
              end else if (!letter_ok || load_depth >= DEPTH_W'(MAX_PATTERN_LEN)) begin
                o_status_next = letter_ok ? ST_FULL : ST_LETTER;
                if (req.last) begin
                  load_node_next  = '0;
                  load_depth_next = '0;
                end
              end else begin
                out_valid_next = 1'b0;
                nr_en = 1'b1; nr_addr = load_node;
                state_next = L_CHK;
              end
            end
            OP_BUILD: begin
              out_valid_next = 1'b0;
              state_next = B_START;
            end
            OP_SCAN: begin
              if (!links_built) begin
                o_status_next = ST_PHASE;
              end else if (!letter_ok) begin
                scan_node_next = '0;
              end else begin
                out_valid_next = 1'b0;
                p_r_next = scan_node;
                nr_en = 1'b1; nr_addr = scan_node;
                state_next = C_PCHK;
              end
            end
            OP_READ: begin
              if (req.pattern_index == '0 || req.pattern_index > ID_W'(PATTERNS) ||
                  req.pattern_index >= next_id) begin
                o_status_next = ST_PHASE;
              end else begin
                out_valid_next = 1'b0;
                cr_en = 1'b1;
                cr_addr = CADDR_W'(req.pattern_index - 1'b1);
                state_next = R_WAIT;
              end
            end
            OP_CLEAR: begin
              scan_node_next   = '0;
              load_node_next   = '0;
              nodes_used_next  = NCOUNT_W'(1);
              next_id_next     = ID_W'(1);
              links_built_next = 1'b0;
              load_depth_next  = '0;
              state_next       = S_ROOT;
            end
            default: o_status_next = ST_PHASE;
          endcase
        end
      end

      // ---- pattern load ----
      L_CHK: begin
        if (pc == '0 && nodes_used >= NCOUNT_W'(NODES)) begin
          out_valid_next = 1'b1;
          o_status_next  = ST_FULL;
          if (last_r) begin
            load_node_next  = '0;
            load_depth_next = '0;
          end
          state_next = S_IDLE;
        end else if (pc == '0) begin
          nw_one = 1'b1; nw_addr = load_node; nw_k = k_r;
          nw_node = nodes_used[NODE_W-1:0];
          c_r_next = nodes_used[NODE_W-1:0];
          nodes_used_next = nodes_used + 1'b1;
          state_next = L_INIT;
        end else begin
          load_node_next  = pc;
          load_depth_next = load_depth + 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
          if (last_r) begin
            load_node_next  = '0;
            load_depth_next = '0;
            if (next_id > ID_W'(PATTERNS)) begin
              o_status_next = ST_FULL;
            end else begin
              nw_pat = 1'b1; nw_addr = pc; nw_id = next_id;
              cw_en = 1'b1; cw_addr = CADDR_W'(next_id - 1'b1);
              o_pid_next   = next_id;
              next_id_next = next_id + 1'b1;
            end
          end
        end
      end

      L_INIT: begin
        // fresh node: clear its row, tag it when it ends a pattern
        nw_kids = 1'b1; nw_pat = 1'b1; nw_addr = c_r; nw_id = '0;
        load_node_next  = c_r;
        load_depth_next = load_depth + 1'b1;
        out_valid_next  = 1'b1;
        state_next      = S_IDLE;
        if (last_r) begin
          load_node_next  = '0;
          load_depth_next = '0;
          if (next_id > ID_W'(PATTERNS)) begin
            o_status_next = ST_FULL;
          end else begin
            nw_id = next_id;
            cw_en = 1'b1; cw_addr = CADDR_W'(next_id - 1'b1);
            o_pid_next   = next_id;
            next_id_next = next_id + 1'b1;
          end
        end
      end

      // ---- failure link build, breadth first ----
      B_START: begin
        nw_fail = 1'b1; nw_q = 1'b1; nw_addr = '0; nw_node = '0;
        head_next  = '0;
        tail_next  = NCOUNT_W'(1);
        state_next = B_QRD;
      end

      B_QRD: begin
        if (head == tail) begin
          links_built_next = 1'b1;
          scan_node_next   = '0;
          out_valid_next   = 1'b1;
          state_next       = S_IDLE;
        end else begin
          nr_en = 1'b1; nr_addr = head[NODE_W-1:0];
          state_next = B_QWAIT;
        end
      end

      B_QWAIT: begin
        u_r_next  = node_rd[Q_LSB +: NODE_W];
        nr_en = 1'b1; nr_addr = node_rd[Q_LSB +: NODE_W];
        head_next  = head + 1'b1;
        state_next = B_UROW;
      end

      B_UROW: begin
        u_row_next = node_rd;
        kk_next    = '0;
        state_next = B_K;
      end

      B_K: begin
        if (cc == '0) begin
          if (kk == LETTER_W'(ALPHABET - 1)) state_next = B_QRD;
          else kk_next = kk + 1'b1;
        end else begin
          c_r_next = cc;
          if (u_r == '0) begin
            f_r_next   = '0;
            state_next = B_WF;
          end else begin
            p_r_next = fail_of(u_row);
            nr_en = 1'b1; nr_addr = fail_of(u_row);
            k_r_next   = kk;
            state_next = B_PCHK;
          end
        end
      end

      B_PCHK: begin
        if (p_r != '0 && pc == '0) begin
          p_r_next = fail_of(node_rd);
          nr_en = 1'b1; nr_addr = fail_of(node_rd);
        end else begin
          f_r_next   = pc;
          state_next = B_WF;
        end
      end

      B_WF: begin
        nw_fail = 1'b1; nw_addr = c_r; nw_node = f_r;
        state_next = B_WQ;
      end

      B_WQ: begin
        nw_q = 1'b1; nw_addr = tail[NODE_W-1:0]; nw_node = c_r;
        tail_next = tail + 1'b1;
        if (kk == LETTER_W'(ALPHABET - 1)) begin
          state_next = B_QRD;
        end else begin
          kk_next    = kk + 1'b1;
          state_next = B_K;
        end
      end

      // ---- text scan ----
      C_PCHK: begin
        if (p_r != '0 && pc == '0) begin
          p_r_next = fail_of(node_rd);
          nr_en = 1'b1; nr_addr = fail_of(node_rd);
        end else begin
          scan_node_next = pc;
          here_next      = '0;
          if (pc == '0) begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            nr_en = 1'b1; nr_addr = pc;
            state_next = C_TCHK;
          end
        end
      end

      C_TCHK: begin
        tf_r_next = fail_of(node_rd);
        if (id_ok) begin
          cr_en = 1'b1; cr_addr = CADDR_W'(tid - 1'b1);
          cw_addr = CADDR_W'(tid - 1'b1);
          p_r_next   = {{(NODE_W-CADDR_W){1'b0}}, CADDR_W'(tid - 1'b1)};
          state_next = C_CINC;
        end else if (fail_of(node_rd) == '0) begin
          out_valid_next = 1'b1;
          o_here_next    = here;
          state_next     = S_IDLE;
        end else begin
          nr_en = 1'b1; nr_addr = fail_of(node_rd);
        end
      end

      C_CINC: begin
        // count read-modify-write; next read waits for this write
        cw_en   = 1'b1;
        cw_addr = p_r[CADDR_W-1:0];
        cw_data = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
        here_next = (here == '1) ? here : here + 1'b1;
        if (tf_r == '0) begin
          out_valid_next = 1'b1;
          o_here_next    = (here == '1) ? here : here + 1'b1;
          state_next     = S_IDLE;
        end else begin
          nr_en = 1'b1; nr_addr = tf_r;
          state_next = C_TCHK;
        end
      end

      R_WAIT: begin
        out_valid_next = 1'b1;
        o_cnt_next     = cnt_rd;
        state_next     = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_ROOT;
      scan_node   <= '0;
      load_node   <= '0;
      nodes_used  <= NCOUNT_W'(1);
      next_id     <= ID_W'(1);
      links_built <= 1'b0;
      load_depth  <= '0;
      head        <= '0;
      tail        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      scan_node   <= scan_node_next;
      load_node   <= load_node_next;
      nodes_used  <= nodes_used_next;
      next_id     <= next_id_next;
      links_built <= links_built_next;
      load_depth  <= load_depth_next;
      head        <= head_next;
      tail        <= tail_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_r_next;
    last_r   <= last_r_next;
    kk       <= kk_next;
    u_r      <= u_r_next;
    c_r      <= c_r_next;
    f_r      <= f_r_next;
    p_r      <= p_r_next;
    tf_r     <= tf_r_next;
    u_row    <= u_row_next;
    here     <= here_next;
    o_pid    <= o_pid_next;
    o_cnt    <= o_cnt_next;
    o_here   <= o_here_next;
    o_status <= o_status_next;
  end

endmodule

### tb/sv/multi_pattern_match_counter_tb.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_counter_tb
// Self-checking bench for the Aho-Corasick match counter. A queue of request
// items feeds a clocked driver; each accepted item is run through an internal
// trie predictor and the result items are checked field by field, in order.
// ----------------------------------------------------------------------------
module multi_pattern_match_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 64;

  // idling modes: none, sender gaps, receiver stalls, both
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [2:0]   op;
    logic [7:0]   symbol;
    logic         last;
    id_t          index;
    idle_mode_t   mode;
    bit           hold;    // wait until nothing is outstanding before driving
  } req_item_t;

  typedef struct {
    id_t                 pid;
    count_t              count;
    logic [HERE_W-1:0]   here;
    logic [1:0]          status;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpmc_req_if req_ch ();
  mpmc_rsp_if rsp_ch ();

  multi_pattern_match_counter uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  req_item_t pending_items[$];
  rsp_item_t expected_results[$];
  int        errors = 0;
  int        ops_seen[8];
  int        results_checked = 0;
  int        idle_cycles = 0;
  bit        req_took = 1'b0;
  idle_mode_t drive_mode = IDLE_NONE;

  // ---------------------------------------------------------------- predictor
  // Sparse trie: child table keyed by node * ALPHABET + letter.
  int unsigned trie_child[int];
  int unsigned trie_fail[NODES];
  int unsigned trie_pat[int];
  longint unsigned pat_count[PATTERNS];
  int unsigned scan_at, load_at, nodes_in_use, id_next, load_len;
  bit links_ready;

  function automatic int unsigned kid(int unsigned n, int k);
    int key;
    key = int'(n) * ALPHABET + k;
    return trie_child.exists(key) ? trie_child[key] : 0;
  endfunction

  function automatic int unsigned pat_at(int unsigned n);
    return trie_pat.exists(int'(n)) ? trie_pat[int'(n)] : 0;
  endfunction

  function automatic void clear_trie();
    trie_child.delete();
    trie_pat.delete();
    foreach (pat_count[i]) pat_count[i] = 0;
    scan_at = 0;
    load_at = 0;
    nodes_in_use = 1;
    id_next = 1;
    links_ready = 0;
    load_len = 0;
  endfunction

  function automatic int letter_of(logic [7:0] s);
    if (s < CHAR_A || s > CHAR_Z) return -1;
    return int'(s - CHAR_A);
  endfunction

  // breadth-first failure links
  function automatic void link_trie();
    int unsigned bfs[$];
    int unsigned u, c, p;
    trie_fail[0] = 0;
    bfs.push_back(0);
    while (bfs.size() > 0) begin
      u = bfs.pop_front();
      for (int k = 0; k < ALPHABET; k++) begin
        c = kid(u, k);
        if (c != 0) begin
          if (u == 0) begin
            trie_fail[c] = 0;
          end else begin
            p = trie_fail[u];
            while (p != 0 && kid(p, k) == 0) p = trie_fail[p];
            trie_fail[c] = kid(p, k);
          end
          bfs.push_back(c);
        end
      end
    end
    links_ready = 1;
    scan_at = 0;
  endfunction

  function automatic rsp_item_t predict_result(req_item_t it);
    rsp_item_t r;
    int k;
    int unsigned c, p, id;
    r = '{pid: '0, count: '0, here: '0, status: ST_OK};
    k = letter_of(it.symbol);
    case (it.op)
      OP_LOAD: begin
        if (links_ready) begin
          r.status = ST_PHASE;
        end else if (k < 0 || load_len >= MAX_PATTERN_LEN) begin
          r.status = (k < 0) ? ST_LETTER : ST_FULL;
          if (it.last) begin
            load_at = 0;
            load_len = 0;
          end
        end else begin
          c = kid(load_at, k);
          if (c == 0 && nodes_in_use >= NODES) begin
            r.status = ST_FULL;
            if (it.last) begin
              load_at = 0;
              load_len = 0;
            end
          end else begin
            if (c == 0) begin
              c = nodes_in_use++;
              trie_child[int'(load_at) * ALPHABET + k] = c;
            end
            load_at = c;
            load_len++;
            if (it.last) begin
              if (id_next > PATTERNS) begin
                r.status = ST_FULL;
              end else begin
                trie_pat[int'(c)] = id_next;
                r.pid = id_t'(id_next);
                id_next++;
              end
              load_at = 0;
              load_len = 0;
            end
          end
        end
      end
      OP_BUILD: link_trie();
      OP_SCAN: begin
        if (!links_ready) begin
          r.status = ST_PHASE;
        end else if (k < 0) begin
          scan_at = 0;
        end else begin
          p = scan_at;
          while (p != 0 && kid(p, k) == 0) p = trie_fail[p];
          p = kid(p, k);
          scan_at = p;
          // walk the output chain
          for (int unsigned t = p; t != 0; t = trie_fail[t]) begin
            id = pat_at(t);
            if (id >= 1 && id <= PATTERNS) begin
              if (pat_count[id-1] < 64'hFFFF_FFFF) pat_count[id-1]++;
              if (r.here < 127) r.here++;
            end
          end
        end
      end
      OP_READ: begin
        if (it.index == 0 || it.index > PATTERNS || it.index >= id_next)
          r.status = ST_PHASE;
        else
          r.count = count_t'(pat_count[it.index-1]);
      end
      OP_CLEAR: clear_trie();
      default: r.status = ST_PHASE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  function automatic int unsigned send_gap_pct(idle_mode_t m);
    return (m == IDLE_SEND) ? 48 : (m == IDLE_BOTH) ? 38 : 0;
  endfunction

  function automatic int unsigned recv_stall_pct(idle_mode_t m);
    return (m == IDLE_RECV) ? 48 : (m == IDLE_BOTH) ? 38 : 0;
  endfunction

  // Monitor: results are checked before the new request is predicted, since
  // a result seen on the same edge always belongs to an earlier item.
  always @(posedge clk) begin
    rsp_item_t want;
    req_item_t got_req;
    req_took <= !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result item with nothing expected", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (rsp_ch.pattern_id !== want.pid)
            report_mismatch("pattern_id", rsp_ch.pattern_id, want.pid);
          if (rsp_ch.match_count !== want.count)
            report_mismatch("match_count", rsp_ch.match_count, want.count);
          if (rsp_ch.matches_here !== want.here)
            report_mismatch("matches_here", rsp_ch.matches_here, want.here);
          if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got_req = '{op: req_ch.op, symbol: req_ch.symbol, last: req_ch.last,
                    index: req_ch.pattern_index, mode: IDLE_NONE, hold: 0};
        expected_results.push_back(predict_result(got_req));
        ops_seen[req_ch.op]++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    req_item_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_took) begin
        if (pending_items.size() > 0 &&
            !(pending_items[0].hold &&
              (expected_results.size() > 0 || (req_ch.valid && !req_took))) &&
            $urandom_range(99) >= send_gap_pct(pending_items[0].mode)) begin
          nxt = pending_items.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.op            <= nxt.op;
          req_ch.symbol        <= nxt.symbol;
          req_ch.last          <= nxt.last;
          req_ch.pattern_index <= nxt.index;
          drive_mode = nxt.mode;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct(drive_mode));
    end
  end

  // ---------------------------------------------------------------- stimulus
  idle_mode_t gen_mode = IDLE_NONE;
  bit         gen_hold = 0;

  task automatic add(logic [2:0] op, logic [7:0] sym = 8'h41, logic lst = 0,
                     id_t idx = 1);
    pending_items.push_back('{op: op, symbol: sym, last: lst, index: idx,
                              mode: gen_mode, hold: gen_hold});
    gen_hold = 0;
  endtask

  task automatic add_pattern(string s);
    for (int i = 0; i < s.len(); i++) add(OP_LOAD, s[i], i == s.len() - 1);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add(OP_SCAN, s[i]);
  endtask

  function automatic logic [7:0] rnd_letter(int span);
    return CHAR_A + 8'($urandom_range(span - 1));
  endfunction

  task automatic add_noise();
    add(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
        id_t'($urandom_range(2047)));
  endtask

  // one clear/load/build/scan/read round with random content
  task automatic add_round();
    int span, npat, len, nloaded;
    span = $urandom_range(2, 6);
    npat = $urandom_range(2, 8);
    nloaded = 0;
    gen_hold = 1;
    add(OP_CLEAR);
    if ($urandom_range(3) == 0) add(OP_SCAN, rnd_letter(span));   // before build
    for (int p = 0; p < npat; p++) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(29) == 0)
          add(OP_LOAD, 8'($urandom_range(255)), i == len - 1);     // likely bad
        else
          add(OP_LOAD, ($urandom_range(15) == 0) ? rnd_letter(26) : rnd_letter(span),
              i == len - 1);
      end
      nloaded++;
    end
    add(OP_BUILD);
    if ($urandom_range(1)) add(OP_LOAD, rnd_letter(span), 1);      // load after build
    for (int i = 0; i < 30; i++) begin
      case ($urandom_range(19))
        0:       add_noise();
        1:       add(OP_SCAN, 8'($urandom_range(255)));
        2:       add(OP_READ, 8'($urandom_range(255)), 0, id_t'($urandom_range(2047)));
        3, 4:    add(OP_READ, 8'h00, 0, id_t'($urandom_range(nloaded + 2)));
        5:       if ($urandom_range(3) == 0) add(OP_BUILD);
        default: add(OP_SCAN, rnd_letter(span));
      endcase
    end
    for (int i = 1; i <= nloaded + 1; i++) add(OP_READ, 8'h00, 0, id_t'(i));
  endtask

  task automatic wait_all_done();
    while (pending_items.size() > 0 || req_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  string s;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_LOAD;
    req_ch.symbol = 8'h00;
    req_ch.last = 1'b0;
    req_ch.pattern_index = '0;
    rsp_ch.ready = 1'b0;
    clear_trie();

    // directed: phase errors, bad letters, duplicate, textbook text
    add(OP_SCAN, "S");                 // scan before build
    add(OP_LOAD, 8'h61, 0);            // lowercase letter dropped
    add(OP_LOAD, 8'h40, 1);            // bad final letter abandons pattern
    add_pattern("HE");
    add_pattern("SHE");
    add_pattern("HERS");
    add_pattern("HE");                 // duplicate takes the later id
    add(3'd5);
    add(3'd7);
    add(OP_BUILD);
    add(OP_LOAD, "A", 1);              // load after build
    add_text("SHERS");
    add(OP_SCAN, "1");                 // non-letter returns to the root
    add(OP_READ, 8'h00, 0, 0);
    add(OP_READ, 8'h00, 0, 1);
    add(OP_READ, 8'h00, 0, 4);

    // random rounds across every idling mode
    for (int m = 0; m < 4; m++) begin
      gen_mode = idle_mode_t'(m);
      for (int r = 0; r < 3; r++) add_round();
      for (int i = 0; i < 20; i++) add_noise();
    end

    // deepest chain: 64 A's, an over-long 65, then shorter prefixes
    gen_mode = IDLE_BOTH;
    gen_hold = 1;
    add(OP_CLEAR);
    for (int n = 64; n <= 65; n++) begin
      s = "";
      for (int i = 0; i < n; i++) s = {s, "A"};
      add_pattern(s);
    end
    add_pattern("AAA");
    add_pattern("A");
    gen_mode = IDLE_NONE;
    add(OP_BUILD);
    for (int i = 0; i < 66; i++) add(OP_SCAN, "A");
    add(OP_SCAN, "B");
    add(OP_READ, 8'h00, 0, 1);
    add(OP_READ, 8'h00, 0, 2);
    add(OP_READ, 8'h00, 0, 3);
    add(OP_READ, 8'h00, 0, 4);
    add(OP_READ, 8'h00, 0, 1024);
    add(OP_READ, 8'h00, 0, 1025);
    add(OP_READ, 8'h00, 0, 2047);

    gen_hold = 1;
    add(OP_CLEAR);
    add_pattern("AB");
    add(OP_BUILD);
    add_text("ZAB");
    add(OP_READ, 8'h00, 0, 1);

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d loads, %0d builds, %0d scans, %0d reads, %0d clears, %0d bad ops",
             ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], ops_seen[4],
             ops_seen[5] + ops_seen[6] + ops_seen[7]);
    $display("%0d result items checked, %0d mismatches", results_checked, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
